// ===== design/s3ls_pkg.sv =====
// shared types, constants and the divider step for the 3x3 solver
// no dependencies
`default_nettype none

package s3ls_pkg;

	localparam int unsigned ElemW  = 16;
	localparam int unsigned CofW   = 33;
	localparam int unsigned WideW  = 49;
	localparam int unsigned MagW   = 48;
	localparam int unsigned SolW   = 32;
	localparam int unsigned QBits  = 32;
	localparam int unsigned Lanes  = 3;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAw = $clog2(FifoDepth);

	localparam logic [SolW-1:0] SolPosMax = {1'b0, {(SolW-1){1'b1}}};
	localparam logic [SolW-1:0] SolNegMag = {1'b1, {(SolW-1){1'b0}}};

	// one system after the front end: determinant and adjugate-times-rhs
	typedef struct packed {
		logic signed [WideW-1:0] det;
		logic signed [WideW-1:0] num0;
		logic signed [WideW-1:0] num1;
		logic signed [WideW-1:0] num2;
	} sys_t;

	typedef struct packed {
		logic qbit;
		logic [MagW-1:0] rem;
	} step_t;

	// one restoring division step
	function automatic step_t div_step(input logic [MagW-1:0] r, input logic [MagW-1:0] d,
			input logic b);
		logic [MagW:0] t;
		step_t res;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			res.qbit = 1'b1;
			res.rem  = MagW'(t - {1'b0, d});
		end else begin
			res.qbit = 1'b0;
			res.rem  = t[MagW-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== design/s3ls_fifo.sv =====
// short queue between the cofactor front end and the divider back end
// uses s3ls_pkg
`default_nettype none

module s3ls_fifo import s3ls_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  sys_t      push_data,
	output logic      full,
	input  wire logic pop,
	output sys_t      pop_data,
	output logic      empty
);

	sys_t mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_q, rd_q;
	logic [FifoAw:0] cnt_q;

	assign full     = (cnt_q == (FifoAw+1)'(FifoDepth));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== design/s3ls_cof.sv =====
// front end: takes input beats, forms cofactors, determinant and numerators
// uses s3ls_pkg, feeds s3ls_fifo
`default_nettype none

module s3ls_cof import s3ls_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,
	output logic              push,
	output sys_t              push_data,
	input  wire logic         full
);

	// element index r*3+k for the two factors of each minor product
	localparam logic [3:0] PA [18] = '{4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd2, 4'd1, 4'd0,
		4'd2, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1};
	localparam logic [3:0] PB [18] = '{4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd8,
		4'd6, 4'd6, 4'd7, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3};

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [ElemW-1:0] a_s1 [9];
	logic signed [ElemW-1:0] b_s1 [3];
	logic signed [2*ElemW-1:0] p_s2 [18];
	logic signed [ElemW-1:0] a0_s2 [3];
	logic signed [ElemW-1:0] b_s2 [3];
	logic signed [CofW-1:0] c_s3 [9];
	logic signed [ElemW-1:0] a0_s3 [3];
	logic signed [ElemW-1:0] b_s3 [3];
	logic signed [WideW-1:0] dp_s4 [3];
	logic signed [WideW-1:0] np_s4 [9];
	sys_t sys_s5;

	assign en            = !full;
	assign s_axis_tready = en;
	assign push          = v_s5 && en;
	assign push_data     = sys_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) a_s1[i] <= s_axis_tdata[i*ElemW +: ElemW];
			for (int i = 0; i < 3; i++) b_s1[i] <= s_axis_tdata[(9+i)*ElemW +: ElemW];
			for (int i = 0; i < 18; i++) p_s2[i] <= a_s1[PA[i]] * a_s1[PB[i]];
			for (int i = 0; i < 3; i++) begin
				a0_s2[i] <= a_s1[i];
				b_s2[i]  <= b_s1[i];
			end
			for (int i = 0; i < 9; i++) begin
				c_s3[i] <= CofW'(p_s2[2*i]) - CofW'(p_s2[2*i+1]);
			end
			a0_s3 <= a0_s2;
			b_s3  <= b_s2;
			for (int k = 0; k < 3; k++) dp_s4[k] <= WideW'(a0_s3[k]) * WideW'(c_s3[k]);
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					np_s4[r*3+k] <= WideW'(c_s3[r*3+k]) * WideW'(b_s3[r]);
				end
			end
			// sums fit in 49 bits, so wrapping adds are exact
			sys_s5.det  <= dp_s4[0] + dp_s4[1] + dp_s4[2];
			sys_s5.num0 <= np_s4[0] + np_s4[3] + np_s4[6];
			sys_s5.num1 <= np_s4[1] + np_s4[4] + np_s4[7];
			sys_s5.num2 <= np_s4[2] + np_s4[5] + np_s4[8];
		end
	end

endmodule

`default_nettype wire

// ===== design/s3ls_div.sv =====
// back end: three pipelined restoring dividers, rounding, saturation, output register
// uses s3ls_pkg, reads s3ls_fifo
`default_nettype none

module s3ls_div import s3ls_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  sys_t             head,
	input  wire logic        empty,
	output logic             pop,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser
);

	logic en;
	logic v_s1, sing_s1;
	logic [MagW-1:0] n_s1 [Lanes];
	logic [MagW-1:0] d_s1;
	logic neg_s1 [Lanes];

	logic v_s [QBits+1];
	logic sing_s [QBits+1];
	logic [MagW-1:0] d_s [QBits+1];
	logic [MagW-1:0] rem_s [Lanes][QBits+1];
	logic [QBits-1:0] xl_s [Lanes][QBits+1];
	logic [QBits-1:0] quo_s [Lanes][QBits+1];
	logic neg_s [Lanes][QBits+1];
	logic ovf_s [Lanes][QBits+1];

	logic signed [WideW-1:0] num_in [Lanes];
	logic [SolW-1:0] sol_c [Lanes];
	logic sat_c [Lanes];
	logic [95:0] data_q;
	logic [1:0] user_q;
	logic out_v_q;

	assign en  = !out_v_q || m_axis_tready;
	assign pop = en && !empty;
	assign num_in[0] = head.num0;
	assign num_in[1] = head.num1;
	assign num_in[2] = head.num2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			for (int j = 0; j <= QBits; j++) v_s[j] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s[0] <= v_s1;
			for (int j = 0; j < QBits; j++) v_s[j+1] <= v_s[j];
			out_v_q <= v_s[QBits];
		end
	end

	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			logic [QBits-1:0] q;
			q = quo_s[l][QBits];
			if (neg_s[l][QBits]) begin
				sat_c[l] = ovf_s[l][QBits] || (q > SolNegMag);
				sol_c[l] = SolW'(0) - (sat_c[l] ? SolNegMag : q);
			end else begin
				sat_c[l] = ovf_s[l][QBits] || q[QBits-1];
				sol_c[l] = sat_c[l] ? SolPosMax : q;
			end
			if (sing_s[QBits]) begin
				sat_c[l] = 1'b0;
				sol_c[l] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitudes and sign of each quotient
			sing_s1 <= (head.det == '0);
			d_s1    <= head.det[WideW-1] ? MagW'(-head.det) : MagW'(head.det);
			for (int l = 0; l < Lanes; l++) begin
				n_s1[l]   <= num_in[l][WideW-1] ? MagW'(-num_in[l]) : MagW'(num_in[l]);
				neg_s1[l] <= num_in[l][WideW-1] ^ head.det[WideW-1];
			end
			// rounding term added, upper half checked against the divisor
			sing_s[0] <= sing_s1;
			d_s[0]    <= d_s1;
			for (int l = 0; l < Lanes; l++) begin
				logic [63:0] x;
				x = {n_s1[l], 16'b0} + {17'b0, d_s1[MagW-1:1]};
				ovf_s[l][0] <= ({16'b0, x[63:32]} >= d_s1);
				rem_s[l][0] <= {16'b0, x[63:32]};
				xl_s[l][0]  <= x[31:0];
				quo_s[l][0] <= '0;
				neg_s[l][0] <= neg_s1[l];
			end
			for (int j = 0; j < QBits; j++) begin
				sing_s[j+1] <= sing_s[j];
				d_s[j+1]    <= d_s[j];
				for (int l = 0; l < Lanes; l++) begin
					step_t st;
					st = div_step(rem_s[l][j], d_s[j], xl_s[l][j][QBits-1]);
					rem_s[l][j+1] <= st.rem;
					quo_s[l][j+1] <= {quo_s[l][j][QBits-2:0], st.qbit};
					xl_s[l][j+1]  <= {xl_s[l][j][QBits-2:0], 1'b0};
					neg_s[l][j+1] <= neg_s[l][j];
					ovf_s[l][j+1] <= ovf_s[l][j];
				end
			end
			data_q <= {sol_c[2], sol_c[1], sol_c[0]};
			user_q <= {sat_c[0] || sat_c[1] || sat_c[2], sing_s[QBits]};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule

`default_nettype wire

// ===== design/solve_3x3_linear_system.sv =====
// top level of the 3x3 solver: front end, queue and divider back end
// uses s3ls_pkg, s3ls_cof, s3ls_fifo, s3ls_div
//
// channel  dir  width  contents
// s_axis   in   192    tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22 rhs0 rhs1 rhs2
// m_axis   out  96+2   tdata: sol0 sol1 sol2; tuser: singular overflow
//
// one system per cycle while the output is not stalled; the path runs through 5 front
// stages, the queue, 2 setup stages and 32 divider stages (one quotient bit each), then
// the output register
// arst_n clears valid bits, queue pointers and the queue count only
// a stalled output freezes the back end; the queue absorbs the front end until full
`default_nettype none

module solve_3x3_linear_system import s3ls_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22 rhs0 rhs1 rhs2
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [95:0]       m_axis_tdata,  // sol0 sol1 sol2
	output logic [1:0]        m_axis_tuser   // singular overflow
);

	logic push, full, pop, empty;
	sys_t push_data, head;

	s3ls_cof u_cof (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.push, .push_data, .full
	);

	s3ls_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .full, .pop, .pop_data(head), .empty
	);

	s3ls_div u_div (
		.clk, .arst_n, .head, .empty, .pop,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
		else $error("singular result not cleared");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
		m_axis_tdata[31:0] == SolPosMax || m_axis_tdata[31:0] == SolNegMag ||
		m_axis_tdata[63:32] == SolPosMax || m_axis_tdata[63:32] == SolNegMag ||
		m_axis_tdata[95:64] == SolPosMax || m_axis_tdata[95:64] == SolNegMag)
		else $error("overflow without a saturated component");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue overrun");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue underrun");

endmodule

`default_nettype wire
